@@ design/rgb_led_effect_sequencer_macros.svh @@
// Assertion helpers used by the checker file rles_checker.sv.
`ifndef RGB_LED_EFFECT_SEQUENCER_MACROS_SVH
`define RGB_LED_EFFECT_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RLES_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rles check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define RLES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rles check failed: next-cycle implication");

`endif

@@ design/rles_pkg.sv @@
`timescale 1ns / 1ps

package rles_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int MS_W       = 16;
    localparam int MODE_W     = 4;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_EFFECT_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLASH_ON_MS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLASH_OFF_MS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP_MS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP_SIZE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CYCLE_GAP_MS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_DUTY      = 3'd6;

    // Effect mode codes
    localparam logic [MODE_W-1:0] MODE_OFF     = 4'd0;
    localparam logic [MODE_W-1:0] MODE_SOLID_R = 4'd1;
    localparam logic [MODE_W-1:0] MODE_SOLID_G = 4'd2;
    localparam logic [MODE_W-1:0] MODE_SOLID_B = 4'd3;
    localparam logic [MODE_W-1:0] MODE_FLASH_R = 4'd4;
    localparam logic [MODE_W-1:0] MODE_FLASH_G = 4'd5;
    localparam logic [MODE_W-1:0] MODE_FLASH_B = 4'd6;
    localparam logic [MODE_W-1:0] MODE_FLASH_W = 4'd7;
    localparam logic [MODE_W-1:0] MODE_PULSE_R = 4'd8;
    localparam logic [MODE_W-1:0] MODE_PULSE_G = 4'd9;
    localparam logic [MODE_W-1:0] MODE_PULSE_B = 4'd10;
    localparam logic [MODE_W-1:0] MODE_PULSE_W = 4'd11;

    // Reset values
    localparam logic [MS_W-1:0] FLASH_ON_RST  = 16'd500;
    localparam logic [MS_W-1:0] FLASH_OFF_RST = 16'd500;
    localparam logic [MS_W-1:0] STEP_MS_RST   = 16'd40;
    localparam logic [MS_W-1:0] GAP_MS_RST    = 16'd100;
    localparam logic [12:0]     STEP_SIZE_RST = 13'd50;
    localparam logic [12:0]     FULL_DUTY_RST = 13'd8191;

    // Timing and mode settings handed to the pattern engine
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [MS_W-1:0]   flash_on_ms;
        logic [MS_W-1:0]   flash_off_ms;
        logic [MS_W-1:0]   ramp_step_ms;
        logic [MS_W-1:0]   cycle_gap_ms;
    } timing_cfg_t;

endpackage

@@ design/rles_cfg.sv @@
`timescale 1ns / 1ps

module rles_cfg #(
    parameter int DUTY_BITS = 13
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [rles_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rles_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output rles_pkg::timing_cfg_t               timing,
    output logic [DUTY_BITS-1:0]                ramp_step_size,
    output logic [DUTY_BITS-1:0]                full_duty,
    output logic                                restart
);

    rles_pkg::timing_cfg_t timing_reg;
    logic [DUTY_BITS-1:0]  step_size_reg;
    logic [DUTY_BITS-1:0]  full_duty_reg;
    logic [15:0]           duty_wdata;
    logic [15:0]           step_rst_ext;
    logic [15:0]           full_rst_ext;

    // duty registers keep 13 written bits, then the duty width
    assign duty_wdata   = {3'b000, cfg_wdata[12:0]};
    assign step_rst_ext = {3'b000, rles_pkg::STEP_SIZE_RST};
    assign full_rst_ext = {3'b000, rles_pkg::FULL_DUTY_RST};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg.mode         <= rles_pkg::MODE_OFF;
            timing_reg.flash_on_ms  <= rles_pkg::FLASH_ON_RST;
            timing_reg.flash_off_ms <= rles_pkg::FLASH_OFF_RST;
            timing_reg.ramp_step_ms <= rles_pkg::STEP_MS_RST;
            timing_reg.cycle_gap_ms <= rles_pkg::GAP_MS_RST;
            step_size_reg           <= step_rst_ext[DUTY_BITS-1:0];
            full_duty_reg           <= full_rst_ext[DUTY_BITS-1:0];
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                rles_pkg::REG_EFFECT_MODE:    timing_reg.mode <= cfg_wdata[3:0];
                rles_pkg::REG_FLASH_ON_MS:    timing_reg.flash_on_ms <= cfg_wdata;
                rles_pkg::REG_FLASH_OFF_MS:   timing_reg.flash_off_ms <= cfg_wdata;
                rles_pkg::REG_RAMP_STEP_MS:   timing_reg.ramp_step_ms <= cfg_wdata;
                rles_pkg::REG_RAMP_STEP_SIZE: step_size_reg <= duty_wdata[DUTY_BITS-1:0];
                rles_pkg::REG_CYCLE_GAP_MS:   timing_reg.cycle_gap_ms <= cfg_wdata;
                rles_pkg::REG_FULL_DUTY:      full_duty_reg <= duty_wdata[DUTY_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign timing         = timing_reg;
    assign ramp_step_size = step_size_reg;
    assign full_duty      = full_duty_reg;
    assign restart        = cfg_wr_en && (cfg_index == rles_pkg::REG_EFFECT_MODE);

endmodule

@@ design/rles_pattern.sv @@
`timescale 1ns / 1ps

module rles_pattern #(
    parameter int DUTY_BITS = 13
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rles_pkg::timing_cfg_t timing,
    input  logic [DUTY_BITS-1:0]  ramp_step_size,
    input  logic [DUTY_BITS-1:0]  full_duty,
    input  logic                  restart,
    input  logic                  step_en,
    input  logic                  advance,
    output logic [DUTY_BITS-1:0]  red_next,
    output logic [DUTY_BITS-1:0]  green_next,
    output logic [DUTY_BITS-1:0]  blue_next
);

    typedef enum logic [1:0] {
        PH_RISE = 2'd0,     // flash lit / ramp up
        PH_FALL = 2'd1,     // flash dark / ramp down
        PH_GAP  = 2'd2
    } phase_t;

    phase_t                       phase_reg, phase_next;
    logic [rles_pkg::MS_W-1:0]    count_reg, count_next;
    logic [DUTY_BITS-1:0]         level_reg, level_next;

    logic [rles_pkg::MS_W-1:0]    count_inc;
    logic [rles_pkg::MS_W-1:0]    on_len, off_len, step_len, phase_len;
    logic [DUTY_BITS-1:0]         step;
    logic [DUTY_BITS:0]           up_sum;
    logic                         is_flash, is_pulse, is_solid, white;
    logic                         gap_en, len_done, tick;
    logic [2:0]                   colour;
    logic [DUTY_BITS-1:0]         level_out;

    always_comb
    begin
        is_flash = 1'b0;
        is_pulse = 1'b0;
        is_solid = 1'b0;
        case (timing.mode) inside
            [rles_pkg::MODE_SOLID_R:rles_pkg::MODE_SOLID_B]: is_solid = 1'b1;
            [rles_pkg::MODE_FLASH_R:rles_pkg::MODE_FLASH_W]: is_flash = 1'b1;
            [rles_pkg::MODE_PULSE_R:rles_pkg::MODE_PULSE_W]: is_pulse = 1'b1;
            default: ;
        endcase
    end

    // zero lengths and a zero step behave as one
    assign on_len   = (timing.flash_on_ms  == '0) ? 16'd1 : timing.flash_on_ms;
    assign off_len  = (timing.flash_off_ms == '0) ? 16'd1 : timing.flash_off_ms;
    assign step_len = (timing.ramp_step_ms == '0) ? 16'd1 : timing.ramp_step_ms;
    assign step     = (ramp_step_size == '0) ? DUTY_BITS'(1) : ramp_step_size;
    assign gap_en   = (timing.cycle_gap_ms != '0);

    always_comb
    begin
        case (phase_reg)
            PH_RISE: phase_len = is_flash ? on_len  : step_len;
            PH_FALL: phase_len = is_flash ? off_len : step_len;
            default: phase_len = timing.cycle_gap_ms;
        endcase
    end

    assign tick      = step_en && advance && (is_flash || is_pulse);
    assign count_inc = count_reg + 16'd1;
    assign len_done  = (count_inc >= phase_len);
    assign up_sum    = {1'b0, level_reg} + {1'b0, step};

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        level_next = level_reg;
        if (tick)
        begin
            count_next = len_done ? '0 : count_inc;
            if (len_done && is_flash)
            begin
                case (phase_reg)
                    PH_RISE: phase_next = PH_FALL;
                    PH_FALL: phase_next = gap_en ? PH_GAP : PH_RISE;
                    default: phase_next = PH_RISE;
                endcase
            end
            else if (len_done)
            begin
                case (phase_reg)
                    PH_RISE:
                    begin
                        if (up_sum <= {1'b0, full_duty})
                        begin
                            level_next = up_sum[DUTY_BITS-1:0];
                        end
                        else
                        begin
                            phase_next = PH_FALL;
                            level_next = full_duty;
                        end
                    end
                    PH_FALL:
                    begin
                        if (level_reg >= step)
                        begin
                            level_next = level_reg - step;
                        end
                        else if (gap_en)
                        begin
                            phase_next = PH_GAP;
                        end
                        else
                        begin
                            phase_next = PH_RISE;
                            level_next = '0;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_RISE;
                        level_next = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_RISE;
            count_reg <= '0;
            level_reg <= '0;
        end
        else if (restart)
        begin
            phase_reg <= PH_RISE;
            count_reg <= '0;
            level_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            level_reg <= level_next;
        end
    end

    // duty shown is the one after this tick
    assign white = (timing.mode == rles_pkg::MODE_FLASH_W) ||
                   (timing.mode == rles_pkg::MODE_PULSE_W);

    always_comb
    begin
        case (timing.mode)
            rles_pkg::MODE_SOLID_R, rles_pkg::MODE_FLASH_R,
            rles_pkg::MODE_PULSE_R: colour = 3'b001;
            rles_pkg::MODE_SOLID_G, rles_pkg::MODE_FLASH_G,
            rles_pkg::MODE_PULSE_G: colour = 3'b010;
            rles_pkg::MODE_SOLID_B, rles_pkg::MODE_FLASH_B,
            rles_pkg::MODE_PULSE_B: colour = 3'b100;
            default:                colour = white ? 3'b111 : 3'b000;
        endcase
    end

    always_comb
    begin
        if (is_solid)
        begin
            level_out = full_duty;
        end
        else if (is_flash)
        begin
            level_out = (phase_next == PH_RISE) ? full_duty : '0;
        end
        else
        begin
            level_out = level_next;
        end
    end

    assign red_next   = colour[0] ? level_out : '0;
    assign green_next = colour[1] ? level_out : '0;
    assign blue_next  = colour[2] ? level_out : '0;

endmodule

@@ design/rgb_led_effect_sequencer.sv @@
`timescale 1ns / 1ps
// RGB LED effect sequencer.
// Input channel (in_valid / in_stall / advance): one transaction per
// millisecond tick (advance = 1) or a plain status poll (advance = 0).
// Output channel (out_valid / out_stall / red_duty, green_duty, blue_duty):
// exactly one transaction per input transaction, in order, carrying the
// PWM duties after that tick. Unlit channels read 0.
// Configuration: cfg_wr_en / cfg_index / cfg_wdata write one register per
// cycle; writing effect_mode restarts the pattern. Write only while idle.
// Path: the accepting edge loads the input register; the result register
// loads from it when it is free or draining. Throughput: one transaction
// per cycle while out_stall is low; the state update between the two
// registers is combinational.
// Reset (rst_n low, asynchronous): registers take their defaults, pattern
// returns to its start, both pipeline stages empty.
// When out_stall is high the result holds; an empty input register still
// takes one more transaction, then in_stall rises until the output drains.

module rgb_led_effect_sequencer #(
    parameter int DUTY_BITS = 13
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration port
    input  logic                            cfg_wr_en,
    input  logic [rles_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rles_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            advance,
    // output channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [DUTY_BITS-1:0]            red_duty,
    output logic [DUTY_BITS-1:0]            green_duty,
    output logic [DUTY_BITS-1:0]            blue_duty
);

    rles_pkg::timing_cfg_t  timing;
    logic [DUTY_BITS-1:0]   ramp_step_size;
    logic [DUTY_BITS-1:0]   full_duty;
    logic                   restart;

    logic                   s1_vld_reg;
    logic                   s1_adv_reg;
    logic                   out_vld_reg;
    logic [DUTY_BITS-1:0]   red_reg, green_reg, blue_reg;
    logic [DUTY_BITS-1:0]   red_next, green_next, blue_next;
    logic                   s1_go;
    logic                   step_en;

    rles_cfg #(
        .DUTY_BITS (DUTY_BITS)
    ) u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .timing         (timing),
        .ramp_step_size (ramp_step_size),
        .full_duty      (full_duty),
        .restart        (restart)
    );

    // Stage 1 moves forward whenever the result register is free or draining
    assign s1_go    = !out_vld_reg || !out_stall;
    assign in_stall = s1_vld_reg && !s1_go;
    assign step_en  = s1_vld_reg && s1_go;

    rles_pattern #(
        .DUTY_BITS (DUTY_BITS)
    ) u_pattern (
        .clk            (clk),
        .rst_n          (rst_n),
        .timing         (timing),
        .ramp_step_size (ramp_step_size),
        .full_duty      (full_duty),
        .restart        (restart),
        .step_en        (step_en),
        .advance        (s1_adv_reg),
        .red_next       (red_next),
        .green_next     (green_next),
        .blue_next      (blue_next)
    );

    // Valid bits of both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                s1_vld_reg <= in_valid;
            end
            if (s1_go)
            begin
                out_vld_reg <= s1_vld_reg;
            end
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            s1_adv_reg <= advance;
        end
        if (step_en)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign out_valid  = out_vld_reg;
    assign red_duty   = red_reg;
    assign green_duty = green_reg;
    assign blue_duty  = blue_reg;

endmodule

@@ design/rles_checker.sv @@
`timescale 1ns / 1ps
`include "rgb_led_effect_sequencer_macros.svh"

module rles_checker #(
    parameter int DUTY_BITS = 13
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            cfg_wr_en,
    input logic [rles_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [rles_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic                            advance,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [DUTY_BITS-1:0]            red_duty,
    input logic [DUTY_BITS-1:0]            green_duty,
    input logic [DUTY_BITS-1:0]            blue_duty
);

    // a stalled result stays put
    `RLES_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(red_duty) && $stable(green_duty) && $stable(blue_duty))

    // an empty result register never back-pressures the input
    `RLES_ASSERT_IMPLY(a_no_false_stall, clk, rst_n, !out_valid, !in_stall)

    // lit channels always share one level (single colour or white)
    `RLES_ASSERT_IMPLY(a_lit_equal, clk, rst_n, out_valid, (red_duty == '0 || green_duty == '0 || red_duty == green_duty) && (green_duty == '0 || blue_duty == '0 || green_duty == blue_duty) && (red_duty == '0 || blue_duty == '0 || red_duty == blue_duty))

endmodule

bind rgb_led_effect_sequencer rles_checker #(.DUTY_BITS(DUTY_BITS)) u_rles_checker (.*);

@@ dv/led_duty_checker.sv @@
`timescale 1ns / 1ps

module led_duty_checker #(
    parameter int DUTY_BITS = 13
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [rles_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rles_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic                            advance,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [DUTY_BITS-1:0]            red_duty,
    input  logic [DUTY_BITS-1:0]            green_duty,
    input  logic [DUTY_BITS-1:0]            blue_duty,
    output int                              mismatches,
    output int                              in_flight,
    output int                              results_seen
);

    import rles_pkg::*;

    // pattern phases: lit / ramp up, dark / ramp down, gap
    localparam logic [2:0] PH_RISE = 3'd0;
    localparam logic [2:0] PH_FALL = 3'd1;
    localparam logic [2:0] PH_GAP  = 3'd2;

    typedef struct packed {
        logic [DUTY_BITS-1:0] red;
        logic [DUTY_BITS-1:0] green;
        logic [DUTY_BITS-1:0] blue;
    } duty_set_t;

    duty_set_t duty_q[$];
    duty_set_t want;

    // shadow registers
    logic [MODE_W-1:0]    mode;
    logic [MS_W-1:0]      on_ms;
    logic [MS_W-1:0]      off_ms;
    logic [MS_W-1:0]      step_ms;
    logic [MS_W-1:0]      gap_ms;
    logic [DUTY_BITS-1:0] step_size;
    logic [DUTY_BITS-1:0] full;

    // pattern state
    logic [2:0]           phase;
    logic [MS_W-1:0]      ms_count;
    logic [DUTY_BITS-1:0] level;

    int fail_tally;
    int seen_tally;

    function automatic logic [MS_W-1:0] floor_one(input logic [MS_W-1:0] v);
        return (v == '0) ? 16'd1 : v;
    endfunction

    function automatic void restart_pattern();
        phase    = PH_RISE;
        ms_count = '0;
        level    = '0;
    endfunction

    function automatic void flash_tick();
        logic [MS_W-1:0] span;
        if (phase == PH_RISE)
            span = floor_one(on_ms);
        else if (phase == PH_FALL)
            span = floor_one(off_ms);
        else
            span = gap_ms;
        ms_count = ms_count + 16'd1;
        if (ms_count < span)
            return;
        ms_count = '0;
        if (phase == PH_RISE)
            phase = PH_FALL;
        else if (phase == PH_FALL && gap_ms != '0)
            phase = PH_GAP;
        else
            phase = PH_RISE;
    endfunction

    function automatic void pulse_tick();
        logic [MS_W-1:0] span;
        int              stride;
        int              upper;
        span     = (phase >= PH_GAP) ? gap_ms : floor_one(step_ms);
        stride   = floor_one(16'(step_size));
        ms_count = ms_count + 16'd1;
        if (ms_count < span)
            return;
        ms_count = '0;
        if (phase == PH_RISE) begin
            upper = level + stride;
            if (upper <= full) begin
                level = upper[DUTY_BITS-1:0];
            end else begin
                phase = PH_FALL;
                level = full;
            end
        end else if (phase == PH_FALL) begin
            if (level >= stride) begin
                level = level - stride[DUTY_BITS-1:0];
            end else if (gap_ms != '0) begin
                phase = PH_GAP;
            end else begin
                phase = PH_RISE;
                level = '0;
            end
        end else begin
            phase = PH_RISE;
            level = '0;
        end
    endfunction

    // state after the tick, spread over the lit channels
    function automatic duty_set_t predict_duties(input logic tick);
        logic [2:0]           lit;
        logic [DUTY_BITS-1:0] lvl;
        duty_set_t            d;
        lit = '0;
        lvl = '0;
        if (mode >= MODE_SOLID_R && mode <= MODE_SOLID_B) begin
            lit = 3'b001 << (mode - MODE_SOLID_R);
            lvl = full;
        end else if (mode >= MODE_FLASH_R && mode <= MODE_FLASH_W) begin
            if (tick)
                flash_tick();
            lit = (mode == MODE_FLASH_W) ? 3'b111 : 3'b001 << (mode - MODE_FLASH_R);
            lvl = (phase == PH_RISE) ? full : '0;
        end else if (mode >= MODE_PULSE_R && mode <= MODE_PULSE_W) begin
            if (tick)
                pulse_tick();
            lit = (mode == MODE_PULSE_W) ? 3'b111 : 3'b001 << (mode - MODE_PULSE_R);
            lvl = level;
        end
        d.red   = lit[0] ? lvl : '0;
        d.green = lit[1] ? lvl : '0;
        d.blue  = lit[2] ? lvl : '0;
        return d;
    endfunction

    function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_EFFECT_MODE:
            begin
                mode = data[MODE_W-1:0];
                restart_pattern();
            end
            REG_FLASH_ON_MS:    on_ms     = data;
            REG_FLASH_OFF_MS:   off_ms    = data;
            REG_RAMP_STEP_MS:   step_ms   = data;
            REG_RAMP_STEP_SIZE: step_size = data[DUTY_BITS-1:0];
            REG_CYCLE_GAP_MS:   gap_ms    = data;
            REG_FULL_DUTY:      full      = data[DUTY_BITS-1:0];
            default: ;
        endcase
    endfunction

    function automatic int check_field(input string name,
                                       input logic [DUTY_BITS-1:0] exp_v,
                                       input logic [DUTY_BITS-1:0] act_v);
        if (exp_v === act_v)
            return 0;
        $display("%0t ns: %s_duty mismatch: expected %0d, actual %0d",
                 $time, name, exp_v, act_v);
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode      = MODE_OFF;
            on_ms     = FLASH_ON_RST;
            off_ms    = FLASH_OFF_RST;
            step_ms   = STEP_MS_RST;
            step_size = STEP_SIZE_RST;
            gap_ms    = GAP_MS_RST;
            full      = FULL_DUTY_RST;
            restart_pattern();
            duty_q.delete();
            fail_tally   = 0;
            seen_tally   = 0;
            mismatches   <= 0;
            in_flight    <= 0;
            results_seen <= 0;
        end else begin
            if (cfg_wr_en)
                apply_write(cfg_index, cfg_wdata);
            // drain before fill, so a spurious result never meets this cycle's push
            if (out_valid && !out_stall) begin
                seen_tally++;
                if (duty_q.size() == 0) begin
                    $display("%0t ns: unexpected result: expected none, actual r=%0d g=%0d b=%0d",
                             $time, red_duty, green_duty, blue_duty);
                    fail_tally++;
                end else begin
                    want = duty_q.pop_front();
                    fail_tally += check_field("red", want.red, red_duty);
                    fail_tally += check_field("green", want.green, green_duty);
                    fail_tally += check_field("blue", want.blue, blue_duty);
                end
            end
            if (in_valid && !in_stall)
                duty_q.push_back(predict_duties(advance));
            mismatches   <= fail_tally;
            in_flight    <= duty_q.size();
            results_seen <= seen_tally;
        end
    end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    import rles_pkg::*;

    localparam int DUTY_BITS  = 13;
    // nothing accepted for this many cycles means the block is stuck;
    // the longest legal quiet stretch is the receiver's long hold
    localparam int IDLE_LIMIT = 2000;
    localparam int LONG_HOLD  = 200;
    localparam int ITEM_GOAL  = 700;

    // mode numbers the block does not define; they must read as off
    localparam logic [MODE_W-1:0] MODE_UNDEF_LO = 4'd12;
    localparam logic [MODE_W-1:0] MODE_UNDEF_HI = 4'd15;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_wr_en  = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
    logic                  in_valid   = 1'b0;
    logic                  advance    = 1'b0;
    logic                  out_stall  = 1'b0;
    logic                  in_stall;
    logic                  out_valid;
    logic [DUTY_BITS-1:0]  red_duty;
    logic [DUTY_BITS-1:0]  green_duty;
    logic [DUTY_BITS-1:0]  blue_duty;

    int mismatches;
    int in_flight;
    int results_seen;

    int ticks_sent  = 0;
    int polls_sent  = 0;
    int reg_writes  = 0;
    int idle_cycles = 0;

    // knobs shared between the stimulus and the receiver
    bit tx_no_gap     = 1'b0;
    bit rx_no_gap     = 1'b0;
    bit long_hold_req = 1'b0;

    rgb_led_effect_sequencer #(
        .DUTY_BITS(DUTY_BITS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .red_duty   (red_duty),
        .green_duty (green_duty),
        .blue_duty  (blue_duty)
    );

    // watches both channels and the register port, predicts and compares
    led_duty_checker #(
        .DUTY_BITS(DUTY_BITS)
    ) u_duty_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .advance      (advance),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .red_duty     (red_duty),
        .green_duty   (green_duty),
        .blue_duty    (blue_duty),
        .mismatches   (mismatches),
        .in_flight    (in_flight),
        .results_seen (results_seen)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Lower valid and wait until every predicted result has been taken.
    // The first edge is always waited out: in_flight is registered, so a
    // transaction accepted at this edge shows in it only from the next edge.
    task automatic drain_outputs();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (in_flight != 0);
    endtask

    // Register writes happen only with the pipeline empty.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        drain_outputs();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        reg_writes++;
    endtask

    // One input transaction, preceded by a random gap. With no gap, valid
    // simply stays high and only the payload moves on.
    task automatic send_item(input logic adv);
        int gap;
        gap = tx_no_gap ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        advance  <= adv;
        do
            @(posedge clk);
        while (in_stall);
        if (adv)
            ticks_sent++;
        else
            polls_sent++;
    endtask

    // Mostly ticks; polls check that a read alone leaves the pattern alone.
    task automatic run_burst(input int count, input int tick_pct);
        repeat (count) send_item($urandom_range(0, 99) < tick_pct);
    endtask

    // Phase lengths: mostly short so patterns wrap often, some zeros
    // (treated as one) and some full-scale values.
    function automatic logic [CFG_DATA_W-1:0] pick_span();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(6, 20));
            default: return 16'($urandom_range(1, 5));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_gap();
        case ($urandom_range(0, 9))
            0, 1, 2: return 16'd0;
            3:       return 16'hFFFF;
            default: return 16'($urandom_range(1, 6));
        endcase
    endfunction

    // 13-bit registers; upper data bits are sometimes set and must be dropped
    function automatic logic [CFG_DATA_W-1:0] pick_step_size();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(0, 65535));
            4, 5:    return 16'($urandom_range(1, 3000));
            default: return 16'($urandom_range(1, 8191));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_full_duty();
        case ($urandom_range(0, 9))
            0:       return 16'd8191;
            1:       return 16'd1;
            2:       return 16'd0;
            3:       return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(1, 8191));
        endcase
    endfunction

    // Weighted toward the time-varying modes, where the state machine lives.
    function automatic logic [CFG_DATA_W-1:0] pick_mode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 16'($urandom_range(MODE_OFF, MODE_SOLID_B));
        else if (r < 50)
            return 16'($urandom_range(MODE_FLASH_R, MODE_FLASH_W));
        else if (r < 88)
            return 16'($urandom_range(MODE_PULSE_R, MODE_PULSE_W));
        else
            return {12'($urandom_range(0, 4095)),
                    MODE_UNDEF_LO | 4'($urandom_range(0, 3))};
    endfunction

    // A random subset of registers per phase. Without a mode write the
    // pattern keeps running, so full duty can drop under a live ramp.
    task automatic random_setup();
        if ($urandom_range(0, 3) != 0) write_reg(REG_FLASH_ON_MS, pick_span());
        if ($urandom_range(0, 3) != 0) write_reg(REG_FLASH_OFF_MS, pick_span());
        if ($urandom_range(0, 3) != 0) write_reg(REG_RAMP_STEP_MS, pick_span());
        if ($urandom_range(0, 3) != 0) write_reg(REG_RAMP_STEP_SIZE, pick_step_size());
        if ($urandom_range(0, 3) != 0) write_reg(REG_CYCLE_GAP_MS, pick_gap());
        if ($urandom_range(0, 3) != 0) write_reg(REG_FULL_DUTY, pick_full_duty());
        if ($urandom_range(0, 2) != 0) write_reg(REG_EFFECT_MODE, pick_mode());
    endtask

    // ------------------------------------------------------------------
    // Receiver: a random stall per result, none while rx_no_gap is set,
    // and one long hold on request so the pipeline backs up into in_stall.
    // ------------------------------------------------------------------
    initial
    begin : rx_side
        int hold;
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD;
            end else if (rx_no_gap) begin
                hold = 0;
            end else begin
                hold = $urandom_range(0, 9);
            end
            if (hold != 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: counts cycles with no transaction on either channel.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t ns: timeout, no transaction for %0d cycles, %0d results pending",
                     $time, IDLE_LIMIT, in_flight);
            $display("FAILED: results differ");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int phase_no;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part ---
        // reset state: mode off, a tick and a poll both read all zero
        send_item(1'b1);
        send_item(1'b0);

        // solid colors at the reset full duty
        write_reg(REG_EFFECT_MODE, 16'(MODE_SOLID_R));
        send_item(1'b1);
        write_reg(REG_EFFECT_MODE, 16'(MODE_SOLID_G));
        send_item(1'b1);
        write_reg(REG_EFFECT_MODE, 16'(MODE_SOLID_B));
        send_item(1'b1);

        // undefined modes at both ends of the range read as off
        write_reg(REG_EFFECT_MODE, 16'(MODE_UNDEF_LO));
        send_item(1'b1);
        write_reg(REG_EFFECT_MODE, 16'(MODE_UNDEF_HI));
        send_item(1'b1);

        // white flash with zero on/off lengths (act as one) and no gap phase
        write_reg(REG_FLASH_ON_MS, 16'd0);
        write_reg(REG_FLASH_OFF_MS, 16'd0);
        write_reg(REG_CYCLE_GAP_MS, 16'd0);
        write_reg(REG_EFFECT_MODE, 16'(MODE_FLASH_W));
        run_burst(4, 100);
        send_item(1'b0);

        // white pulse, zero step time and size (act as one), tiny full duty:
        // hits the ramp top and bottom and the skipped gap
        write_reg(REG_RAMP_STEP_MS, 16'd0);
        write_reg(REG_RAMP_STEP_SIZE, 16'd0);
        write_reg(REG_FULL_DUTY, 16'd2);
        write_reg(REG_EFFECT_MODE, 16'(MODE_PULSE_W));
        run_burst(7, 100);

        // red pulse with the largest step and full duty, one-ms gap;
        // the step write carries set upper bits that must be dropped
        write_reg(REG_RAMP_STEP_SIZE, 16'hFFFF);
        write_reg(REG_FULL_DUTY, 16'd8191);
        write_reg(REG_CYCLE_GAP_MS, 16'd1);
        write_reg(REG_RAMP_STEP_MS, 16'd1);
        write_reg(REG_EFFECT_MODE, 16'(MODE_PULSE_R));
        run_burst(5, 100);

        // --- random part: phases of random settings and traffic ---
        phase_no = 0;
        while (ticks_sent + polls_sent < ITEM_GOAL) begin
            random_setup();
            case (phase_no)
                3:
                begin
                    // back-to-back traffic, no idling on either side
                    tx_no_gap = 1'b1;
                    rx_no_gap = 1'b1;
                    run_burst(60, 85);
                    tx_no_gap = 1'b0;
                    rx_no_gap = 1'b0;
                end
                6:
                begin
                    // receiver holds off while the sender keeps pushing
                    long_hold_req = 1'b1;
                    tx_no_gap     = 1'b1;
                    run_burst(40, 90);
                    tx_no_gap     = 1'b0;
                end
                9:
                begin
                    // sender pauses mid-pattern until everything is out
                    run_burst(15, 80);
                    drain_outputs();
                    run_burst(15, 80);
                end
                default: run_burst($urandom_range(10, 50), 80);
            endcase
            phase_no++;
        end

        drain_outputs();
        repeat (10) @(posedge clk);

        $display("Covered %0d tick and %0d poll transactions over %0d random phases",
                 ticks_sent, polls_sent, phase_no);
        $display("with %0d register writes; %0d results compared, %0d mismatches",
                 reg_writes, results_seen, mismatches);
        if (mismatches == 0 && in_flight == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
